/* hdl/rom_ram_window_address_remapper_defines.svh */
// ----------------------------------------------------------------------------
// ROM/RAM window remapper assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ROM_RAM_WINDOW_ADDRESS_REMAPPER_DEFINES_SVH
`define ROM_RAM_WINDOW_ADDRESS_REMAPPER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RRW_ASSERT_IMPLY(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rrw assertion failed");
// next-cycle implication
`define RRW_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rrw assertion failed");
`else
`define RRW_ASSERT_IMPLY(label, ck, rs, ante, cons)
`define RRW_ASSERT_NEXT(label, ck, rs, ante, cons)
`endif
`endif

/* hdl/rrw_pkg.sv */
// ----------------------------------------------------------------------------
// ROM/RAM window remapper package
// Register codes, constants and the decoded window types.
// ----------------------------------------------------------------------------
package rrw_pkg;

  localparam int MAX_WINDOWS = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 57;

  localparam logic [31:0] KSEG1_BASE  = 32'hA000_0000;
  localparam logic [28:0] MIRROR_TOP  = 29'h080_0000;
  localparam logic [28:0] MIRROR_MASK = 29'h01F_FFFF;
  localparam logic [28:0] IMAGE_BASE_RST = 29'h1FC0_0000;
  localparam logic [29:0] IMAGE_SIZE_RST = 30'h0008_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN0_ROM   = 3'd0,
    REG_WIN0_RAM   = 3'd1,
    REG_WIN1_ROM   = 3'd2,
    REG_WIN1_RAM   = 3'd3,
    REG_WIN2_ROM   = 3'd4,
    REG_WIN2_RAM   = 3'd5,
    REG_IMAGE_BASE = 3'd6,
    REG_IMAGE_SIZE = 3'd7
  } cfg_reg_t;

  // one window with its bounds and precomputed offsets
  typedef struct packed {
    logic        en;
    logic        keyram;
    logic [29:0] rlo;
    logic [29:0] rhi;
    logic [29:0] mlo;
    logic [30:0] mhi;
    logic [31:0] off_fwd;    // ROM to RAM: mlo - rlo
    logic [31:0] off_back;   // RAM to ROM: rlo - mlo
    logic [31:0] off_alias;  // (KSEG1 | rlo) - mlo
    logic [31:0] off_rt;     // runtime base - rlo
  } win_t;

  typedef struct packed {
    win_t [MAX_WINDOWS-1:0] win;
    logic [28:0]            img_lo;
    logic [30:0]            img_hi;
  } cfg_t;

endpackage

/* hdl/rrw_cfg.sv */
// ----------------------------------------------------------------------------
// ROM/RAM window remapper configuration
// Register file and registered window decode.
// ----------------------------------------------------------------------------
module rrw_cfg import rrw_pkg::*; #(
  parameter int WINDOW_COUNT = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [56:0] rom_reg [MAX_WINDOWS];
  logic [31:0] ram_reg [MAX_WINDOWS];
  logic [28:0] image_base;
  logic [29:0] image_size;
  cfg_t        cfg_next;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_WINDOWS; i++) begin
        rom_reg[i] <= '0;
        ram_reg[i] <= '0;
      end
      image_base <= IMAGE_BASE_RST;
      image_size <= IMAGE_SIZE_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIN0_ROM:   rom_reg[0] <= cfg_data[56:0];
        REG_WIN0_RAM:   ram_reg[0] <= cfg_data[31:0];
        REG_WIN1_ROM:   rom_reg[1] <= cfg_data[56:0];
        REG_WIN1_RAM:   ram_reg[1] <= cfg_data[31:0];
        REG_WIN2_ROM:   rom_reg[2] <= cfg_data[56:0];
        REG_WIN2_RAM:   ram_reg[2] <= cfg_data[31:0];
        REG_IMAGE_BASE: image_base <= cfg_data[28:0];
        REG_IMAGE_SIZE: image_size <= cfg_data[29:0];
      endcase
    end
  end

  // window decode: bounds, ram end and fold offsets
  always_comb begin
    logic [29:0] len;
    logic [31:0] rtb;
    len = '0;
    rtb = '0;
    cfg_next = '0;
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      cfg_next.win[i].en     = (i < WINDOW_COUNT) && ram_reg[i][31];
      cfg_next.win[i].keyram = rom_reg[i][56];
      cfg_next.win[i].rlo    = {rom_reg[i][27:0], 2'b00};
      cfg_next.win[i].rhi    = {rom_reg[i][55:28], 2'b00};
      cfg_next.win[i].mlo    = {ram_reg[i][27:0], 2'b00};
      len = (cfg_next.win[i].rhi > cfg_next.win[i].rlo) ?
            (cfg_next.win[i].rhi - cfg_next.win[i].rlo) : '0;
      cfg_next.win[i].mhi    = {1'b0, cfg_next.win[i].mlo} + {1'b0, len};
      rtb = {ram_reg[i][30:28], cfg_next.win[i].mlo[28:0]};
      cfg_next.win[i].off_fwd   = {2'b00, cfg_next.win[i].mlo} - {2'b00, cfg_next.win[i].rlo};
      cfg_next.win[i].off_back  = {2'b00, cfg_next.win[i].rlo} - {2'b00, cfg_next.win[i].mlo};
      cfg_next.win[i].off_alias = (KSEG1_BASE | {2'b00, cfg_next.win[i].rlo})
                                  - {2'b00, cfg_next.win[i].mlo};
      cfg_next.win[i].off_rt    = rtb - {2'b00, cfg_next.win[i].rlo};
    end
    cfg_next.img_lo = image_base;
    cfg_next.img_hi = {2'b00, image_base} + {1'b0, image_size};
  end

  // decode register, read by the pipeline from its third stage on
  always_ff @(posedge clk) begin
    cfg <= cfg_next;
  end

endmodule

/* hdl/rrw_pipe.sv */
// ----------------------------------------------------------------------------
// ROM/RAM window remapper pipeline
// Six-stage translation datapath with per-stage valid and stall.
// ----------------------------------------------------------------------------
`include "rom_ram_window_address_remapper_defines.svh"

module rrw_pipe import rrw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] address,
  input  logic [31:0] jump_target,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [28:0] normalized_address,
  output logic [31:0] rom_alias_address,
  output logic [31:0] runtime_address,
  output logic [31:0] relocated_target,
  output logic [28:0] ram_physical_address,
  output logic [31:0] remapped_target
);

  // physical address inside a window's ROM or RAM range
  function automatic logic hit_rom(logic [31:0] p, win_t w);
    return w.en && (p >= {2'b00, w.rlo}) && (p < {2'b00, w.rhi});
  endfunction

  function automatic logic hit_ram(logic [31:0] p, win_t w);
    return w.en && (p >= {2'b00, w.mlo}) && (p < {1'b0, w.mhi});
  endfunction

  // one window fold of the normalized address
  function automatic logic [31:0] win_fold(logic [31:0] n, win_t w);
    logic [31:0] r;
    r = n;
    if (w.keyram && hit_rom(n, w)) begin
      r = n + w.off_fwd;
    end else if (!w.keyram && hit_ram(n, w)) begin
      r = n + w.off_back;
    end
    return r;
  endfunction

  // stage valids and enables
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;

  // stage 1: input beat
  logic [31:0] a1, t1;
  // stage 2: physical and mirror-folded address
  logic [31:0] a2, t2, n2;
  logic [28:0] p2;
  // stage 3: window lookups on the physical address, fold 0
  logic [31:0] a3, t3, n3, alias_off3, ramp_off3, rt_off3;
  logic [28:0] p3;
  logic        alias_hit3, ramp_hit3, rom_hit3;
  // stage 4: alias, runtime, relocation, fold 1
  logic [31:0] t4, n4, alias4, rt4, reloc4;
  logic [28:0] ramp4;
  logic        rom_hit4;
  // stage 5: target lookups, fold 2
  logic [31:0] t5, n5, alias5, rt5, reloc5, remap_off5;
  logic [28:0] ramp5, rp5;
  logic        rom_hit5, rr_hit5, img_hit5;

  always_comb begin
    en6 = !v6 || out_ready;
    en5 = !v5 || en6;
    en4 = !v4 || en5;
    en3 = !v3 || en4;
    en2 = !v2 || en3;
    en1 = !v1 || en2;
  end

  assign in_ready  = en1;
  assign out_valid = v6;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // stage 1 capture
  always_ff @(posedge clk) begin
    if (en1) begin
      a1 <= address;
      t1 <= jump_target;
    end
  end

  // stage 2: mask to physical, fold the main RAM mirror
  always_ff @(posedge clk) begin
    if (en2) begin
      a2 <= a1;
      t2 <= t1;
      p2 <= a1[28:0];
      n2 <= {3'b000, (a1[28:0] < MIRROR_TOP) ? (a1[28:0] & MIRROR_MASK) : a1[28:0]};
    end
  end

  // stage 3: first-match lookups over the windows
  logic        alias_hit_c, ramp_hit_c, rom_hit_c;
  logic [31:0] alias_off_c, ramp_off_c, rt_off_c;

  always_comb begin
    alias_hit_c = 1'b0;
    ramp_hit_c  = 1'b0;
    rom_hit_c   = 1'b0;
    alias_off_c = '0;
    ramp_off_c  = '0;
    rt_off_c    = '0;
    // walk from the last window down so the lowest index wins
    for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
      if (hit_ram({3'b000, p2}, cfg.win[i])) begin
        alias_hit_c = 1'b1;
        alias_off_c = cfg.win[i].off_alias;
      end
      if (hit_rom({3'b000, p2}, cfg.win[i])) begin
        rom_hit_c = 1'b1;
        rt_off_c  = cfg.win[i].off_rt;
        if (cfg.win[i].keyram) begin
          ramp_hit_c = 1'b1;
          ramp_off_c = cfg.win[i].off_fwd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      a3         <= a2;
      t3         <= t2;
      p3         <= p2;
      n3         <= win_fold(n2, cfg.win[0]);
      alias_hit3 <= alias_hit_c;
      alias_off3 <= alias_off_c;
      ramp_hit3  <= ramp_hit_c;
      ramp_off3  <= ramp_off_c;
      rom_hit3   <= rom_hit_c;
      rt_off3    <= rt_off_c;
    end
  end

  // stage 4: apply offsets, relocate the target
  logic [31:0] rt_c, ramp_sum_c;

  always_comb begin
    rt_c       = rom_hit3 ? ({3'b000, p3} + rt_off3) : a3;
    ramp_sum_c = {3'b000, p3} + ramp_off3;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      t4       <= t3;
      n4       <= win_fold(n3, cfg.win[1]);
      alias4   <= alias_hit3 ? ({3'b000, p3} + alias_off3) : a3;
      rt4      <= rt_c;
      reloc4   <= rom_hit3 ? {rt_c[31:28], t3[27:0]} : t3;
      ramp4    <= ramp_hit3 ? ramp_sum_c[28:0] : p3;
      rom_hit4 <= rom_hit3;
    end
  end

  // stage 5: look up the relocated target
  logic        rr_hit_c, img_hit_c;
  logic [31:0] rr_off_c;

  always_comb begin
    rr_hit_c = 1'b0;
    rr_off_c = '0;
    for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
      if (hit_ram({3'b000, reloc4[28:0]}, cfg.win[i])) begin
        rr_hit_c = 1'b1;
        rr_off_c = cfg.win[i].off_alias;
      end
    end
    img_hit_c = (reloc4[28:0] >= cfg.img_lo) && ({2'b00, reloc4[28:0]} < cfg.img_hi);
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      t5         <= t4;
      n5         <= win_fold(n4, cfg.win[2]);
      alias5     <= alias4;
      rt5        <= rt4;
      reloc5     <= reloc4;
      ramp5      <= ramp4;
      rp5        <= reloc4[28:0];
      rom_hit5   <= rom_hit4;
      rr_hit5    <= rom_hit4 && rr_hit_c;
      img_hit5   <= img_hit_c;
      remap_off5 <= rr_off_c;
    end
  end

  // stage 6: remapped target, output register
  logic [31:0] remap_c;

  always_comb begin
    priority if (!rom_hit5) begin
      remap_c = t5;
    end else if (rr_hit5) begin
      remap_c = {3'b000, rp5} + remap_off5;
    end else if (img_hit5) begin
      remap_c = KSEG1_BASE | {3'b000, rp5};
    end else begin
      remap_c = t5;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      normalized_address   <= n5[28:0];
      rom_alias_address    <= alias5;
      runtime_address      <= rt5;
      relocated_target     <= reloc5;
      ram_physical_address <= ramp5;
      remapped_target      <= remap_c;
    end
  end

  // a stalled input means stage 1 is holding a beat
  `RRW_ASSERT_IMPLY(a_ready_low_full, clk, rst, !en1, v1)
  // a ram-keyed ROM hit is also a ROM hit
  `RRW_ASSERT_IMPLY(a_ramp_in_rom, clk, rst, v3 && ramp_hit3, rom_hit3)
  // relocated target keeps the runtime segment nibble
  `RRW_ASSERT_IMPLY(a_reloc_seg, clk, rst, v4 && rom_hit4, reloc4[31:28] == rt4[31:28])
  // a target RAM hit only counts after a ROM hit
  `RRW_ASSERT_IMPLY(a_remap_rom, clk, rst, v5 && rr_hit5, rom_hit5)
  // a stalled stage keeps its beat
  `RRW_ASSERT_NEXT(a_stage5_hold, clk, rst, v5 && !en5, v5 && $stable(n5))

endmodule

/* hdl/rom_ram_window_address_remapper.sv */
// ----------------------------------------------------------------------------
// ROM/RAM window address remapper
// Translates an address and its jump target through up to three windows.
// ----------------------------------------------------------------------------
// Takes one address/target beat per cycle while in_ready is high and returns
// all six translations through the six-stage pipeline, with the three
// sequential window folds of the normalized address taking one stage each.
// Throughput is one beat per clock unless the output side stalls, and each
// stage holds its beat under backpressure. Window and image register writes
// pass through the register file and then the registered decode; write them
// only while no beat is in flight.
module rom_ram_window_address_remapper import rrw_pkg::*; #(
  parameter int WINDOW_COUNT = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input beat
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           address,
  input  logic [31:0]           jump_target,
  // result beat
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [28:0]           normalized_address,
  output logic [31:0]           rom_alias_address,
  output logic [31:0]           runtime_address,
  output logic [31:0]           relocated_target,
  output logic [28:0]           ram_physical_address,
  output logic [31:0]           remapped_target
);

  cfg_t cfg;

  // register file and window decode
  rrw_cfg #(
    .WINDOW_COUNT (WINDOW_COUNT)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // translation pipeline
  rrw_pipe u_pipe (
    .clk                  (clk),
    .rst                  (rst),
    .cfg                  (cfg),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .address              (address),
    .jump_target          (jump_target),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .normalized_address   (normalized_address),
    .rom_alias_address    (rom_alias_address),
    .runtime_address      (runtime_address),
    .relocated_target     (relocated_target),
    .ram_physical_address (ram_physical_address),
    .remapped_target      (remapped_target)
  );

endmodule
